### hdl/cpor_pkg.sv
// shared constants for the circle pair overlap resolver
package cpor_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TOL_BITS       = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;

endpackage

### hdl/cpor_sqrt_stage.sv
// one registered step of the restoring integer square root
module cpor_sqrt_stage #(
  parameter int RW = 34,
  parameter int NW = 68,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rad_in,
  input  logic [RW-1:0] root_in,
  output logic [RW-1:0] root_out
);
  logic [RW-1:0] trial;
  logic [2*RW-1:0] sq;
  logic [2*RW:0] nx;
  always_comb begin
    trial = root_in | (RW'(1) << BIT);
    sq = trial * trial;
    nx = (2*RW+1)'(rad_in);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      root_out <= ({1'b0, sq} <= nx) ? trial : root_in;
    end
  end
endmodule

### hdl/cpor_div_stage.sv
// one registered step of the restoring unsigned divider
module cpor_div_stage #(
  parameter int QW = 70,
  parameter int DW = 36
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem_in,
  input  logic          num_bit,
  input  logic [QW-1:0] q_in,
  output logic [DW-1:0] rem_out,
  output logic [QW-1:0] q_out
);
  logic [DW:0] sh;
  always_comb sh = {rem_in, num_bit};
  always_ff @(posedge clk) begin
    if (en) begin
      if (sh >= {1'b0, den}) begin
        rem_out <= DW'(sh - {1'b0, den});
        q_out   <= {q_in[QW-2:0], 1'b1};
      end else begin
        rem_out <= sh[DW-1:0];
        q_out   <= {q_in[QW-2:0], 1'b0};
      end
    end
  end
endmodule

### hdl/circle_pair_overlap_resolve_core.sv
// top level: pipelined circle overlap test and separation
//
//  channel  | handshake              | payload
//  in       | in_valid / in_stall    | first_*, second_*
//  out      | out_valid / out_stall  | overlapping, moved_*, saturated
//  config   | cfg_we                 | cfg_data (contact tolerance)
//
// one transaction enters per cycle while the output is not stalled; each passes the
// difference and square registers, the bit-per-stage square root chain, a product
// register, the bit-per-stage divider chain and the output register, in that order.
// the whole pipe advances together; a stall at the output holds every stage.
// reset clears valid bits and sets the tolerance to its default.
module circle_pair_overlap_resolve_core #(
  parameter int COORD_BITS = cpor_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cpor_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic [COORD_BITS-2:0] first_radius,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic [COORD_BITS-2:0] second_radius,
  input  logic cfg_we,
  input  logic [cpor_pkg::TOL_BITS-1:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic overlapping,
  output logic signed [COORD_BITS-1:0] moved_first_x,
  output logic signed [COORD_BITS-1:0] moved_first_y,
  output logic signed [COORD_BITS-1:0] moved_second_x,
  output logic signed [COORD_BITS-1:0] moved_second_y,
  output logic saturated
);
  import cpor_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int AW = C + 1;          // |d| width
  localparam int NW = 2 * AW + 1;     // sum of squares
  localparam int RW = AW + 1;         // root width
  localparam int DW = RW + 2;         // divisor 2*dist and remainder
  localparam int MW = RW;             // |diff| width
  localparam int PW = MW + AW;        // product width
  localparam int WW = C + 3;          // output math width
  localparam int NS = 2 + RW + 1 + PW + 1;
  localparam int FB = FRAC_BITS;
  // 0.001 in coordinate units, rounded
  localparam logic [TOL_BITS-1:0] TOL_INIT = TOL_BITS'(((longint'(1) << FB) + 500) / 1000);

  logic adv;
  logic [NS-1:0] vld;
  logic [TOL_BITS-1:0] tol;

  assign adv = !(vld[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_INIT;
      vld <= '0;
    end else begin
      if (cfg_we) tol <= cfg_data;
      if (adv) vld <= {vld[NS-2:0], in_valid};
    end
  end

  typedef struct packed {
    logic signed [C-1:0] fx, fy, sx, sy;
    logic [C-2:0] fr, sr;
  } ctx_t;

  // stage 0: differences
  ctx_t c0;
  logic [AW-1:0] ax0, ay0;
  logic sgx0, sgy0;
  always_ff @(posedge clk) begin
    if (adv) begin
      c0 <= '{first_x, first_y, second_x, second_y, first_radius, second_radius};
      ax0 <= (second_x > first_x) ? AW'($signed({second_x[C-1], second_x}) -
             $signed({first_x[C-1], first_x})) : AW'($signed({first_x[C-1], first_x}) -
             $signed({second_x[C-1], second_x}));
      ay0 <= (second_y > first_y) ? AW'($signed({second_y[C-1], second_y}) -
             $signed({first_y[C-1], first_y})) : AW'($signed({first_y[C-1], first_y}) -
             $signed({second_y[C-1], second_y}));
      sgx0 <= second_x > first_x;
      sgy0 <= second_y > first_y;
    end
  end

  // stage 1: squares
  ctx_t c1;
  logic [AW-1:0] ax1, ay1;
  logic sgx1, sgy1;
  logic [NW-1:0] n1;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= c0; ax1 <= ax0; ay1 <= ay0; sgx1 <= sgx0; sgy1 <= sgy0;
      n1 <= NW'(ax0 * ax0) + NW'(ay0 * ay0);
    end
  end

  // square root chain
  ctx_t cr [RW+1];
  logic [AW-1:0] axr [RW+1];
  logic [AW-1:0] ayr [RW+1];
  logic [NW-1:0] nr [RW+1];
  logic [RW-1:0] rr [RW+1];
  logic sgxr [RW+1];
  logic sgyr [RW+1];
  always_comb begin
    cr[0] = c1; axr[0] = ax1; ayr[0] = ay1; nr[0] = n1; rr[0] = '0;
    sgxr[0] = sgx1; sgyr[0] = sgy1;
  end
  for (genvar i = 0; i < RW; i++) begin : g_sq
    cpor_sqrt_stage #(.RW(RW), .NW(NW), .BIT(RW-1-i)) u_sq (
      .clk(clk), .en(adv), .rad_in(nr[i]), .root_in(rr[i]), .root_out(rr[i+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        cr[i+1] <= cr[i]; axr[i+1] <= axr[i]; ayr[i+1] <= ayr[i];
        nr[i+1] <= nr[i]; sgxr[i+1] <= sgxr[i]; sgyr[i+1] <= sgyr[i];
      end
    end
  end

  // products |d|*|diff|
  ctx_t cp;
  logic [PW-1:0] px, py;
  logic [DW-1:0] den;
  logic neg, ovl, zer, sgxp, sgyp;
  logic signed [MW:0] diff;
  always_comb diff = $signed((MW+1)'(cr[RW].fr)) + $signed((MW+1)'(cr[RW].sr)) -
                     $signed((MW+1)'(rr[RW]));
  logic [MW-1:0] adiff;
  always_comb adiff = diff[MW] ? MW'(-diff) : MW'(diff);
  always_ff @(posedge clk) begin
    if (adv) begin
      cp <= cr[RW]; sgxp <= sgxr[RW]; sgyp <= sgyr[RW];
      px <= PW'(axr[RW]) * PW'(adiff);
      py <= PW'(ayr[RW]) * PW'(adiff);
      den <= {1'b0, rr[RW], 1'b0};
      neg <= diff[MW];
      ovl <= diff >= $signed({1'b0, (MW)'(tol)});
      zer <= (axr[RW] == '0) && (ayr[RW] == '0);
    end
  end

  // division chain
  ctx_t cd [PW+1];
  logic [PW-1:0] nx [PW+1];
  logic [PW-1:0] ny [PW+1];
  logic [DW-1:0] rx [PW+1];
  logic [DW-1:0] ry [PW+1];
  logic [PW-1:0] qx [PW+1];
  logic [PW-1:0] qy [PW+1];
  logic [DW-1:0] dd [PW+1];
  logic ngd [PW+1];
  logic ovd [PW+1];
  logic zd [PW+1];
  logic sxd [PW+1];
  logic syd [PW+1];
  always_comb begin
    cd[0] = cp; nx[0] = px; ny[0] = py; rx[0] = '0; ry[0] = '0;
    qx[0] = '0; qy[0] = '0; dd[0] = den; ngd[0] = neg; ovd[0] = ovl;
    zd[0] = zer; sxd[0] = sgxp; syd[0] = sgyp;
  end
  for (genvar j = 0; j < PW; j++) begin : g_dv
    cpor_div_stage #(.QW(PW), .DW(DW)) u_dx (
      .clk(clk), .en(adv), .den(dd[j]), .rem_in(rx[j]), .num_bit(nx[j][PW-1-j]),
      .q_in(qx[j]), .rem_out(rx[j+1]), .q_out(qx[j+1]));
    cpor_div_stage #(.QW(PW), .DW(DW)) u_dy (
      .clk(clk), .en(adv), .den(dd[j]), .rem_in(ry[j]), .num_bit(ny[j][PW-1-j]),
      .q_in(qy[j]), .rem_out(ry[j+1]), .q_out(qy[j+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        cd[j+1] <= cd[j]; nx[j+1] <= nx[j]; ny[j+1] <= ny[j]; dd[j+1] <= dd[j];
        ngd[j+1] <= ngd[j]; ovd[j+1] <= ovd[j]; zd[j+1] <= zd[j];
        sxd[j+1] <= sxd[j]; syd[j+1] <= syd[j];
      end
    end
  end

  // final: apply, saturate
  function automatic logic signed [WW-1:0] cap(input logic [PW-1:0] q);
    cap = (q > PW'({WW-1{1'b1}} >> 1)) ? WW'({WW-1{1'b1}} >> 1) : WW'(q);
  endfunction

  logic signed [WW-1:0] dxs, dys, mfx, mfy, msx, msy;
  logic signed [C-1:0] o_fx, o_fy, o_sx, o_sy;
  logic s_fx, s_fy, s_sx, s_sy;
  ctx_t cf;
  always_comb begin
    cf = cd[PW];
    dxs = ngd[PW] ? -cap(qx[PW]) : cap(qx[PW]);
    dys = ngd[PW] ? -cap(qy[PW]) : cap(qy[PW]);
    if (zd[PW]) begin
      msx = WW'(cf.sx) + $signed(WW'(cf.sr));
      mfx = WW'(cf.fx) - $signed(WW'(cf.fr));
      msy = WW'(cf.sy);
      mfy = WW'(cf.fy);
    end else begin
      msx = sxd[PW] ? WW'(cf.sx) + dxs : WW'(cf.sx) - dxs;
      mfx = sxd[PW] ? WW'(cf.fx) - dxs : WW'(cf.fx) + dxs;
      msy = syd[PW] ? WW'(cf.sy) + dys : WW'(cf.sy) - dys;
      mfy = syd[PW] ? WW'(cf.fy) - dys : WW'(cf.fy) + dys;
    end
  end

  function automatic logic [C:0] clip(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] hi, lo;
    hi = WW'({1'b0, {C-1{1'b1}}});
    lo = -hi - WW'(1);
    if (v > hi) clip = {1'b1, hi[C-1:0]};
    else if (v < lo) clip = {1'b1, lo[C-1:0]};
    else clip = {1'b0, v[C-1:0]};
  endfunction

  always_comb begin
    {s_fx, o_fx} = clip(mfx);
    {s_fy, o_fy} = clip(mfy);
    {s_sx, o_sx} = clip(msx);
    {s_sy, o_sy} = clip(msy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      overlapping <= ovd[PW];
      moved_first_x <= o_fx; moved_first_y <= o_fy;
      moved_second_x <= o_sx; moved_second_y <= o_sy;
      saturated <= s_fx | s_fy | s_sx | s_sy;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(moved_first_x))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("spurious input stall");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !vld[0]) else $error("bubble lost");
`endif
endmodule
